FILE: rtl/core/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg
// Types and codes shared by the motor command guard: item structs, mode
// states, operation, action, error and configuration register codes.
// ----------------------------------------------------------------------------
package mcg_pkg;

  // field widths
  localparam int FREQ_W    = 20;
  localparam int FAULT_W   = 8;
  localparam int OP_W      = 4;
  localparam int ACT_W     = 3;
  localparam int MODE_W    = 2;
  localparam int ERR_W     = 3;
  localparam int CFG_IDX_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_START_FWD   = 4'd0;
  localparam logic [OP_W-1:0] OP_START_BACK  = 4'd1;
  localparam logic [OP_W-1:0] OP_CHANGE_FREQ = 4'd2;
  localparam logic [OP_W-1:0] OP_STOP        = 4'd3;
  localparam logic [OP_W-1:0] OP_ESTOP       = 4'd4;
  localparam logic [OP_W-1:0] OP_RESET_ESTOP = 4'd5;
  localparam logic [OP_W-1:0] OP_DRV_STOPPED = 4'd6;
  localparam logic [OP_W-1:0] OP_DRV_ESTOP   = 4'd7;
  localparam logic [OP_W-1:0] OP_DRV_FAULT   = 4'd8;

  // drive actions
  localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START_FWD  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_START_BACK = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SET_FREQ   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STOP       = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ESTOP      = 3'd5;

  // reported mode codes
  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BACK  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ESTOP = 2'd3;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK          = 3'd0;
  localparam logic [ERR_W-1:0] ERR_EMERGENCY   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_RUNNING     = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NOT_RUNNING = 3'd3;
  localparam logic [ERR_W-1:0] ERR_FREQ        = 3'd4;
  localparam logic [ERR_W-1:0] ERR_FWD_LIMIT   = 3'd5;
  localparam logic [ERR_W-1:0] ERR_BACK_LIMIT  = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ = 2'd1;

  // configuration reset values
  localparam logic [FREQ_W-1:0] MIN_FREQ_RST = FREQ_W'(1);
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST = '1;

  // motor mode state, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FWD   = 4'b0010,
    S_BACK  = 4'b0100,
    S_ESTOP = 4'b1000
  } mode_state_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [FREQ_W-1:0]  frequency_hz;
    logic               limit_end;
    logic               limit_home;
    logic [FAULT_W-1:0] fault_in;
  } mcg_in_t;

  typedef struct packed {
    logic [ACT_W-1:0]   drive_action;
    logic [FREQ_W-1:0]  drive_frequency;
    logic [MODE_W-1:0]  motor_mode;
    logic [FREQ_W-1:0]  running_frequency;
    logic [FAULT_W-1:0] fault_code;
    logic [ERR_W-1:0]   error_code;
  } mcg_out_t;

  typedef struct packed {
    logic [FREQ_W-1:0] min_frequency;
    logic [FREQ_W-1:0] max_frequency;
  } mcg_cfg_t;

  // one-hot state to reported mode code
  function automatic logic [MODE_W-1:0] mode_code(mode_state_t s);
    logic [MODE_W-1:0] code;
    unique case (s)
      S_IDLE:  code = MODE_IDLE;
      S_FWD:   code = MODE_FWD;
      S_BACK:  code = MODE_BACK;
      S_ESTOP: code = MODE_ESTOP;
      default: code = MODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/core/mcg_cfg_regs.sv
// ----------------------------------------------------------------------------
// mcg_cfg_regs
// Frequency range registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module mcg_cfg_regs
  import mcg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_data,
  output mcg_cfg_t             cfg
);

  logic [FREQ_W-1:0] min_freq_r;
  logic [FREQ_W-1:0] max_freq_r;
  logic [FREQ_W-1:0] min_freq_nxt;
  logic [FREQ_W-1:0] max_freq_nxt;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register decode, unknown indexes are dropped
  always_comb begin
    min_freq_nxt = min_freq_r;
    max_freq_nxt = max_freq_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_FREQ: min_freq_nxt = cfg_data;
        CFG_MAX_FREQ: max_freq_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_freq_r <= MIN_FREQ_RST;
      max_freq_r <= MAX_FREQ_RST;
    end else begin
      min_freq_r <= min_freq_nxt;
      max_freq_r <= max_freq_nxt;
    end
  end

  assign cfg.min_frequency = min_freq_r;
  assign cfg.max_frequency = max_freq_r;

endmodule

FILE: rtl/core/mcg_core.sv
// ----------------------------------------------------------------------------
// mcg_core
// Guard state (mode, running frequency, latched fault) and the single-pass
// check and update logic for one operation.
// ----------------------------------------------------------------------------
module mcg_core
  import mcg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     exec,
  input  mcg_in_t  item,
  input  mcg_cfg_t cfg,
  output mcg_out_t result
);

  mode_state_t        mode_r;
  mode_state_t        mode_nxt;
  logic [FREQ_W-1:0]  freq_r;
  logic [FREQ_W-1:0]  freq_nxt;
  logic [FAULT_W-1:0] fault_r;
  logic [FAULT_W-1:0] fault_nxt;
  logic [ACT_W-1:0]   action;
  logic [FREQ_W-1:0]  dfreq;
  logic [ERR_W-1:0]   err;
  logic               running;
  logic               freq_ok;
  logic               is_fwd;
  logic               limit_hit;

  assign running   = (mode_r == S_FWD) || (mode_r == S_BACK);
  assign freq_ok   = (item.frequency_hz >= cfg.min_frequency) &&
                     (item.frequency_hz <= cfg.max_frequency);
  assign is_fwd    = (item.operation == OP_START_FWD);
  assign limit_hit = is_fwd ? item.limit_end : item.limit_home;

  // operation decode, first failing check wins
  always_comb begin
    mode_nxt  = mode_r;
    freq_nxt  = freq_r;
    fault_nxt = fault_r;
    action    = ACT_NONE;
    dfreq     = '0;
    err       = ERR_OK;
    unique case (item.operation) inside
      OP_START_FWD, OP_START_BACK: begin
        if (mode_r == S_ESTOP) begin
          err = ERR_EMERGENCY;
        end else if (running) begin
          err = ERR_RUNNING;
        end else if (!freq_ok) begin
          err = ERR_FREQ;
        end else if (limit_hit) begin
          err = is_fwd ? ERR_FWD_LIMIT : ERR_BACK_LIMIT;
        end else begin
          action   = is_fwd ? ACT_START_FWD : ACT_START_BACK;
          dfreq    = item.frequency_hz;
          mode_nxt = is_fwd ? S_FWD : S_BACK;
          freq_nxt = item.frequency_hz;
        end
      end
      OP_CHANGE_FREQ: begin
        if (!running) begin
          err = ERR_NOT_RUNNING;
        end else if (!freq_ok) begin
          err = ERR_FREQ;
        end else begin
          action   = ACT_SET_FREQ;
          dfreq    = item.frequency_hz;
          freq_nxt = item.frequency_hz;
        end
      end
      OP_STOP: begin
        if (running) begin
          action   = ACT_STOP;
          mode_nxt = S_IDLE;
          freq_nxt = '0;
        end
      end
      OP_ESTOP: begin
        action   = ACT_ESTOP;
        mode_nxt = S_ESTOP;
        freq_nxt = '0;
      end
      OP_RESET_ESTOP: begin
        if (mode_r == S_ESTOP) begin
          fault_nxt = '0;
          mode_nxt  = S_IDLE;
        end
      end
      OP_DRV_STOPPED: begin
        mode_nxt = S_IDLE;
        freq_nxt = '0;
      end
      OP_DRV_ESTOP: begin
        mode_nxt = S_ESTOP;
        freq_nxt = '0;
      end
      OP_DRV_FAULT: begin
        fault_nxt = item.fault_in;
        mode_nxt  = S_ESTOP;
        freq_nxt  = '0;
      end
      default: ;
    endcase
  end

  // state advances only when an item is executed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= S_IDLE;
      freq_r  <= '0;
      fault_r <= '0;
    end else if (exec) begin
      mode_r  <= mode_nxt;
      freq_r  <= freq_nxt;
      fault_r <= fault_nxt;
    end
  end

  // result reflects the state after this item
  assign result.drive_action      = action;
  assign result.drive_frequency   = dfreq;
  assign result.motor_mode        = mode_code(mode_nxt);
  assign result.running_frequency = freq_nxt;
  assign result.fault_code        = fault_nxt;
  assign result.error_code        = err;

endmodule

FILE: rtl/core/mcg_out_reg.sv
// ----------------------------------------------------------------------------
// mcg_out_reg
// Result register holding one item until the receiver takes it.
// ----------------------------------------------------------------------------
module mcg_out_reg
  import mcg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  mcg_out_t result,
  output logic     out_valid,
  input  logic     out_ready,
  output mcg_out_t out_data
);

  logic     valid_r;
  logic     valid_nxt;
  mcg_out_t data_r;

  // load wins over a drain in the same cycle
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: rtl/core/motor_command_guard_fsm_top.sv
// ----------------------------------------------------------------------------
// motor_command_guard_fsm_top
// Motor command guard: checks host commands and driver events against the
// current motor mode, frequency range and limit switches.
//
// Usage:
//   in_*  : one operation per item (command or driver event), valid/ready.
//   out_* : exactly one result per item: drive action, drive frequency,
//           new mode, running frequency, latched fault and error code.
//   cfg_* : min/max frequency registers, index 0 and 1; write only while
//           no item is in flight. cfg_ready is always high.
// Timing:
//   an item is registered at acceptance; once the result register is free
//   or draining, it is checked, applied to the state and loaded into the
//   result register, which raises out_valid. One item per cycle is
//   sustained while out_ready stays high; the rate is set by the state
//   update between input and result registers.
// Reset and stalls:
//   reset gives mode idle, frequency 0, no fault, range 1 to all ones.
//   while out_ready is low the result holds; the input register still takes
//   one more item, then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module motor_command_guard_fsm_top
  import mcg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mcg_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mcg_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_data
);

  logic     in_v_r;
  logic     in_v_nxt;
  mcg_in_t  in_item_r;
  logic     advance;
  mcg_cfg_t cfg;
  mcg_out_t result;

  // held item moves on when the result register is free or draining
  assign advance  = in_v_r && (!out_valid || out_ready);
  assign in_ready = !in_v_r || advance;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  mcg_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mcg_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .exec   (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  mcg_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/mcg_checker.sv
// ----------------------------------------------------------------------------
// mcg_checker
// Port-level checks on the motor command guard, bound to the top level.
// ----------------------------------------------------------------------------
module mcg_checker
  import mcg_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input mcg_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a rejected operation issues no drive command
  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error_code != ERR_OK) |->
      (out_data.drive_action == ACT_NONE) && (out_data.drive_frequency == '0))
    else $error("drive command issued with an error");

  // emergency stopped and idle never carry a running frequency
  a_stopped_no_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.motor_mode == MODE_ESTOP) ||
                  (out_data.motor_mode == MODE_IDLE)) |->
      out_data.running_frequency == '0)
    else $error("frequency held while not running");

  // a start command matches the new mode and frequency
  a_start_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.drive_action == ACT_START_FWD) ||
                  (out_data.drive_action == ACT_START_BACK)) |->
      (out_data.running_frequency == out_data.drive_frequency) &&
      (((out_data.drive_action == ACT_START_FWD) &&
        (out_data.motor_mode == MODE_FWD)) ||
       ((out_data.drive_action == ACT_START_BACK) &&
        (out_data.motor_mode == MODE_BACK))))
    else $error("start command disagrees with reported state");

endmodule

bind motor_command_guard_fsm_top mcg_checker u_mcg_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor command guard. Commands and driver events
// go in over valid/ready with random gaps, results are taken with random
// back-pressure and compared field by field against a cycle-free model of
// the mode, frequency and fault state. The frequency range registers are
// reprogrammed between traffic phases, extremes and an inverted range
// included.
// ----------------------------------------------------------------------------
module tb;
  import mcg_pkg::*;

  localparam int DRAIN_CYCLES   = 4;
  localparam int END_CYCLES     = 8;
  localparam int STALL_LIMIT    = 2000;
  localparam int PHASE_ITEMS    = 280;
  localparam int MAX_REPORTED   = 100;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  mcg_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  mcg_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FREQ_W-1:0]    cfg_data;

  // tracked guard state and range registers
  logic [MODE_W-1:0]    track_mode;
  logic [FREQ_W-1:0]    track_run_hz;
  logic [FAULT_W-1:0]   track_fault;
  logic [FREQ_W-1:0]    range_min_hz;
  logic [FREQ_W-1:0]    range_max_hz;

  mcg_out_t             pending_guard_results[$];
  int                   mismatch_count;
  int                   quiet_cycles;
  int                   ready_hold;
  bit                   no_idle;

  motor_command_guard_fsm_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // next result of the guard for one accepted item, state updated in place
  function automatic mcg_out_t guard_next_result(mcg_in_t cmd);
    mcg_out_t res;
    logic     running;
    logic     in_range;
    running  = (track_mode == MODE_FWD) || (track_mode == MODE_BACK);
    in_range = (cmd.frequency_hz >= range_min_hz) && (cmd.frequency_hz <= range_max_hz);
    res = '0;
    res.drive_action = ACT_NONE;
    res.error_code   = ERR_OK;
    case (cmd.operation)
      OP_START_FWD, OP_START_BACK: begin
        if (track_mode == MODE_ESTOP)
          res.error_code = ERR_EMERGENCY;
        else if (running)
          res.error_code = ERR_RUNNING;
        else if (!in_range)
          res.error_code = ERR_FREQ;
        else if (cmd.operation == OP_START_FWD && cmd.limit_end)
          res.error_code = ERR_FWD_LIMIT;
        else if (cmd.operation == OP_START_BACK && cmd.limit_home)
          res.error_code = ERR_BACK_LIMIT;
        else begin
          res.drive_action    = (cmd.operation == OP_START_FWD) ? ACT_START_FWD
                                                                : ACT_START_BACK;
          res.drive_frequency = cmd.frequency_hz;
          track_mode          = (cmd.operation == OP_START_FWD) ? MODE_FWD : MODE_BACK;
          track_run_hz        = cmd.frequency_hz;
        end
      end
      OP_CHANGE_FREQ: begin
        if (!running)
          res.error_code = ERR_NOT_RUNNING;
        else if (!in_range)
          res.error_code = ERR_FREQ;
        else begin
          res.drive_action    = ACT_SET_FREQ;
          res.drive_frequency = cmd.frequency_hz;
          track_run_hz        = cmd.frequency_hz;
        end
      end
      OP_STOP: begin
        if (running) begin
          res.drive_action = ACT_STOP;
          track_mode       = MODE_IDLE;
          track_run_hz     = '0;
        end
      end
      OP_ESTOP: begin
        res.drive_action = ACT_ESTOP;
        track_mode       = MODE_ESTOP;
        track_run_hz     = '0;
      end
      OP_RESET_ESTOP: begin
        if (track_mode == MODE_ESTOP) begin
          track_fault = '0;
          track_mode  = MODE_IDLE;
        end
      end
      OP_DRV_STOPPED: begin
        track_mode   = MODE_IDLE;
        track_run_hz = '0;
      end
      OP_DRV_ESTOP: begin
        track_mode   = MODE_ESTOP;
        track_run_hz = '0;
      end
      OP_DRV_FAULT: begin
        track_fault  = cmd.fault_in;
        track_mode   = MODE_ESTOP;
        track_run_hz = '0;
      end
      default: ;
    endcase
    res.motor_mode        = track_mode;
    res.running_frequency = track_run_hz;
    res.fault_code        = track_fault;
    return res;
  endfunction

  function automatic mcg_in_t make_command(logic [OP_W-1:0] op, logic [FREQ_W-1:0] hz,
                                           logic lim_end, logic lim_home,
                                           logic [FAULT_W-1:0] fault);
    mcg_in_t cmd;
    cmd.operation    = op;
    cmd.frequency_hz = hz;
    cmd.limit_end    = lim_end;
    cmd.limit_home   = lim_home;
    cmd.fault_in     = fault;
    return cmd;
  endfunction

  // frequency biased to the range edges and just outside them
  function automatic logic [FREQ_W-1:0] pick_frequency();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    case (roll)
      0:       return range_min_hz;
      1:       return range_max_hz;
      2:       return range_min_hz - 1'b1;
      3:       return range_max_hz + 1'b1;
      4:       return '0;
      5:       return '1;
      6, 7, 8: return FREQ_W'($urandom);
      default: begin
        if (range_min_hz <= range_max_hz)
          return FREQ_W'($urandom_range(range_max_hz, range_min_hz));
        return FREQ_W'($urandom);
      end
    endcase
  endfunction

  function automatic mcg_in_t random_command();
    mcg_in_t     cmd;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 18)      cmd.operation = OP_START_FWD;
    else if (roll < 36) cmd.operation = OP_START_BACK;
    else if (roll < 54) cmd.operation = OP_CHANGE_FREQ;
    else if (roll < 64) cmd.operation = OP_STOP;
    else if (roll < 69) cmd.operation = OP_ESTOP;
    else if (roll < 79) cmd.operation = OP_RESET_ESTOP;
    else if (roll < 84) cmd.operation = OP_DRV_STOPPED;
    else if (roll < 89) cmd.operation = OP_DRV_ESTOP;
    else if (roll < 95) cmd.operation = OP_DRV_FAULT;
    else                cmd.operation = OP_W'($urandom_range(9, 15));
    cmd.frequency_hz = pick_frequency();
    cmd.limit_end    = ($urandom_range(0, 3) == 0);
    cmd.limit_home   = ($urandom_range(0, 3) == 0);
    cmd.fault_in     = FAULT_W'($urandom);
    return cmd;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTED)
      $display("tb: mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // one command item, valid held until taken
  task automatic send_command(input mcg_in_t cmd);
    int gap;
    gap = no_idle ? 0 : idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    pending_guard_results.push_back(guard_next_result(cmd));
  endtask

  // input idle and every result back, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_guard_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [FREQ_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_FREQ: range_min_hz = value;
      CFG_MAX_FREQ: range_max_hz = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_range(input logic [FREQ_W-1:0] lo, input logic [FREQ_W-1:0] hi);
    wait_idle();
    write_register(CFG_MIN_FREQ, lo);
    write_register(CFG_MAX_FREQ, hi);
  endtask

  // every operation from the reset range, each rule and rejection at least once
  task automatic test_directed_ops();
    send_command(make_command(OP_STOP, 20'd100, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_RESET_ESTOP, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_CHANGE_FREQ, 20'd100, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_W'(9), '1, 1'b1, 1'b1, 8'hFF));
    send_command(make_command(OP_W'(15), '1, 1'b1, 1'b1, 8'hFF));
    send_command(make_command(OP_START_FWD, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_START_FWD, '1, 1'b1, 1'b0, 8'h00));
    send_command(make_command(OP_START_BACK, 20'd1, 1'b0, 1'b1, 8'h00));
    send_command(make_command(OP_START_BACK, 20'd1, 1'b1, 1'b0, 8'h00));
    send_command(make_command(OP_START_FWD, 20'd200, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_CHANGE_FREQ, '1, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_CHANGE_FREQ, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_STOP, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_START_FWD, '1, 1'b0, 1'b1, 8'h00));
    send_command(make_command(OP_DRV_STOPPED, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_START_FWD, 20'd500, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_ESTOP, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_START_BACK, 20'd500, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_CHANGE_FREQ, 20'd500, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_STOP, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_RESET_ESTOP, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_DRV_FAULT, 20'd0, 1'b0, 1'b0, 8'hFF));
    send_command(make_command(OP_ESTOP, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_RESET_ESTOP, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_DRV_FAULT, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_DRV_ESTOP, 20'd0, 1'b0, 1'b0, 8'h00));
  endtask

  // degenerate ranges: single point at zero, and minimum above maximum
  task automatic test_range_settings();
    program_range('0, '0);
    send_command(make_command(OP_RESET_ESTOP, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_START_FWD, 20'd1, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_START_FWD, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_CHANGE_FREQ, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_STOP, 20'd0, 1'b0, 1'b0, 8'h00));
    program_range('1, '0);
    send_command(make_command(OP_START_BACK, 20'd0, 1'b0, 1'b0, 8'h00));
    send_command(make_command(OP_START_BACK, '1, 1'b0, 1'b0, 8'h00));
  endtask

  // random traffic under one range setting, first stretch without idling
  task automatic test_random_traffic(input logic [FREQ_W-1:0] lo,
                                     input logic [FREQ_W-1:0] hi);
    program_range(lo, hi);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      no_idle = (n < PHASE_ITEMS / 5);
      send_command(random_command());
    end
    no_idle = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    mcg_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_guard_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_guard_results.pop_front();
        check_field("drive_action", 32'(out_data.drive_action), 32'(want.drive_action));
        check_field("drive_frequency", 32'(out_data.drive_frequency),
                    32'(want.drive_frequency));
        check_field("motor_mode", 32'(out_data.motor_mode), 32'(want.motor_mode));
        check_field("running_frequency", 32'(out_data.running_frequency),
                    32'(want.running_frequency));
        check_field("fault_code", 32'(out_data.fault_code), 32'(want.fault_code));
        check_field("error_code", 32'(out_data.error_code), 32'(want.error_code));
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // result back-pressure
  initial begin
    out_ready  = 1'b0;
    ready_hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (no_idle) begin
        out_ready  <= 1'b1;
        ready_hold = 0;
      end else if (ready_hold > 0) begin
        ready_hold--;
      end else if ($urandom_range(0, 2) != 0) begin
        out_ready  <= 1'b1;
        ready_hold = $urandom_range(0, 6);
      end else begin
        out_ready  <= 1'b0;
        ready_hold = idle_gap();
      end
    end
  end

  // main sequence
  initial begin
    logic [FREQ_W-1:0] lo;
    logic [FREQ_W-1:0] hi;
    logic [FREQ_W-1:0] point;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_MIN_FREQ;
    cfg_data       = '0;
    no_idle        = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    track_mode     = MODE_IDLE;
    track_run_hz   = '0;
    track_fault    = '0;
    range_min_hz   = MIN_FREQ_RST;
    range_max_hz   = MAX_FREQ_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_range_settings();

    lo    = FREQ_W'($urandom);
    hi    = FREQ_W'($urandom);
    point = FREQ_W'($urandom);
    if (lo > hi) begin
      lo = lo ^ hi;
      hi = lo ^ hi;
      lo = lo ^ hi;
    end
    test_random_traffic('0, '1);
    test_random_traffic(lo, hi);
    test_random_traffic(point, point);
    test_random_traffic('1, '1);
    test_random_traffic(hi, lo);
    test_random_traffic(MIN_FREQ_RST, MAX_FREQ_RST);

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
